@@ hw/rtl/iprc_pkg.sv @@
// Shared constants, result word type and signature lookup for the IPS record counter.
`default_nettype none
package iprc_pkg;

   localparam int CountBitsDefault = 24;
   localparam int RecordBits       = 24;
   localparam int SigLength        = 5;
   localparam int MinFileBytes     = 8;

   // "EOF" split as the two held bytes and the closing byte
   localparam logic [15:0] EofHigh = 16'h454F;
   localparam logic [7:0]  EofLow  = 8'h46;

   // "PATCH", indexed by byte position
   localparam logic [7:0] SigByte0 = 8'h50;
   localparam logic [7:0] SigByte1 = 8'h41;
   localparam logic [7:0] SigByte2 = 8'h54;
   localparam logic [7:0] SigByte3 = 8'h43;
   localparam logic [7:0] SigByte4 = 8'h48;

   typedef struct packed {
      logic                  size_ok;
      logic                  magic_ok;
      logic [RecordBits-1:0] rec_total;
   } rsp_word_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] value;
      case (idx)
         3'd0:    value = SigByte0;
         3'd1:    value = SigByte1;
         3'd2:    value = SigByte2;
         3'd3:    value = SigByte3;
         3'd4:    value = SigByte4;
         default: value = SigByte0;
      endcase
      return value;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/iprc_parser.sv @@
// Byte-wise IPS parse state: signature check, record walk, result word formation.
`default_nettype none
module iprc_parser #(
   parameter int COUNT_BITS = iprc_pkg::CountBitsDefault
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  wire [7:0]             data_byte,
   input  wire                   last_byte,
   output iprc_pkg::rsp_word_type result
);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_OFFSET,
      PH_SIZE,
      PH_SKIP,
      PH_DONE
   } phase_type;

   localparam int WideBits = (COUNT_BITS > iprc_pkg::RecordBits) ?
                             COUNT_BITS : iprc_pkg::RecordBits;
   localparam logic [WideBits-1:0] OutMax = WideBits'({iprc_pkg::RecordBits{1'b1}});

   phase_type             phase_ff, phase_in;
   logic [2:0]            field_ff, field_in;
   logic                  match_ff, match_in;
   logic [15:0]           held_ff, held_in;
   logic [15:0]           skip_ff, skip_in;
   logic [COUNT_BITS-1:0] rec_ff, rec_in;
   logic [3:0]            bytes_ff, bytes_in;

   logic [15:0]           size_word;
   logic [15:0]           skip_dec;
   logic [WideBits-1:0]   rec_wide;
   logic                  size_ok;
   logic                  magic_ok;

   always_comb begin
      phase_in  = phase_ff;
      field_in  = field_ff;
      match_in  = match_ff;
      held_in   = held_ff;
      skip_in   = skip_ff;
      rec_in    = rec_ff;
      bytes_in  = (bytes_ff < 4'(iprc_pkg::MinFileBytes)) ? bytes_ff + 4'd1 : bytes_ff;
      size_word = {held_ff[7:0], data_byte};
      skip_dec  = (skip_ff != 16'd0) ? skip_ff - 16'd1 : skip_ff;

      case (phase_ff)
         PH_MAGIC: begin
            match_in = match_ff & (data_byte == iprc_pkg::sig_byte(field_ff));
            field_in = field_ff + 3'd1;
            if (field_ff == 3'(iprc_pkg::SigLength - 1)) begin
               field_in = 3'd0;
               phase_in = match_in ? PH_OFFSET : PH_DONE;
            end
         end
         PH_OFFSET: begin
            if (field_ff < 3'd2) begin
               held_in  = {held_ff[7:0], data_byte};
               field_in = field_ff + 3'd1;
            end else begin
               field_in = 3'd0;
               if (held_ff == iprc_pkg::EofHigh && data_byte == iprc_pkg::EofLow) begin
                  phase_in = PH_DONE;
               end else begin
                  if (rec_ff != {COUNT_BITS{1'b1}}) rec_in = rec_ff + 1'b1;
                  held_in  = 16'd0;
                  phase_in = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            if (field_ff == 3'd0) begin
               held_in  = {8'd0, data_byte};
               field_in = 3'd1;
            end else begin
               // zero size means an RLE run: two count bytes and one fill byte
               skip_in  = (size_word == 16'd0) ? 16'd3 : size_word;
               held_in  = 16'd0;
               field_in = 3'd0;
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               field_in = 3'd0;
               held_in  = 16'd0;
               phase_in = PH_OFFSET;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rec_wide = WideBits'(rec_in);
      size_ok  = (bytes_in >= 4'(iprc_pkg::MinFileBytes));
      magic_ok = size_ok & match_in;
      result.size_ok  = size_ok;
      result.magic_ok = magic_ok;
      if (!magic_ok) begin
         result.rec_total = '0;
      end else if (rec_wide > OutMax) begin
         result.rec_total = OutMax[iprc_pkg::RecordBits-1:0];
      end else begin
         result.rec_total = rec_wide[iprc_pkg::RecordBits-1:0];
      end
   end

   // the final byte of a file returns everything to the start of a new file
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff <= PH_MAGIC;
         field_ff <= 3'd0;
         match_ff <= 1'b1;
         held_ff  <= 16'd0;
         skip_ff  <= 16'd0;
         rec_ff   <= '0;
         bytes_ff <= 4'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         field_ff <= field_in;
         match_ff <= match_in;
         held_ff  <= held_in;
         skip_ff  <= skip_in;
         rec_ff   <= rec_in;
         bytes_ff <= bytes_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/iprc_rsp_queue.sv @@
// Two-entry result queue between the parse stage and the rsp channel.
`default_nettype none
module iprc_rsp_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  iprc_pkg::rsp_word_type push_word,
   output logic                   has_space,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output iprc_pkg::rsp_word_type rsp_word
);

   iprc_pkg::rsp_word_type entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign has_space = (count_ff != 2'd2);
   assign rsp_word  = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_word;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> has_space)
      else $error("result pushed into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && !rsp_valid) |=> (rsp_valid && rsp_word == $past(push_word)))
      else $error("pushed word not presented");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (rd_ptr_ff != wr_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

@@ hw/rtl/ips_patch_record_counter_unit.sv @@
// IPS patch record counter: input word register, parse stage, result queue.
// A final byte's result is formed from the input register and registered into the queue before it is on rsp.
// Throughput: one byte per cycle, set by the parse state, which updates on each stepped byte;
// bytes that are not final never wait on the rsp side.
// A final byte waits in the input register only while the two-entry result queue is full.
// Reset (synchronous) clears parse state, input register valid and queue; no clearing pass.
`default_nettype none
module ips_patch_record_counter_unit #(
   parameter int COUNT_BITS = iprc_pkg::CountBitsDefault
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [7:0]                          req_data_byte,
   input  wire                                 req_last_byte,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_size_ok,
   output logic                                rsp_magic_ok,
   output logic [iprc_pkg::RecordBits-1:0]     rsp_rec_total
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       step;
   logic       has_space;

   iprc_pkg::rsp_word_type parse_word;
   iprc_pkg::rsp_word_type out_word;

   // a final byte needs a free queue slot; others always move on
   assign step      = in_valid_ff && (!in_last_ff || has_space);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (step)              in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   iprc_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .result    (parse_word)
   );

   iprc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step && in_last_ff),
      .push_word (parse_word),
      .has_space (has_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (out_word)
   );

   assign rsp_size_ok   = out_word.size_ok;
   assign rsp_magic_ok  = out_word.magic_ok;
   assign rsp_rec_total = out_word.rec_total;

endmodule
`default_nettype wire

@@ dv/ips_patch_record_counter_unit_tb.sv @@
// Self-checking testbench for the IPS patch record counter unit.
`timescale 1ns / 100ps
module ips_patch_record_counter_unit_tb;

   localparam int CountBits  = iprc_pkg::CountBitsDefault;
   localparam int CycleLimit = 200000;

   typedef enum logic [2:0] {
      PARSE_MAGIC,
      PARSE_OFFSET,
      PARSE_SIZE,
      PARSE_SKIP,
      PARSE_DONE
   } parse_phase_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_data_byte = 8'h00;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_size_ok;
   logic                            rsp_magic_ok;
   logic [iprc_pkg::RecordBits-1:0] rsp_rec_total;

   // parse state mirror
   parse_phase_type       walk_phase;
   logic [2:0]            field_index;
   logic                  magic_match;
   logic [15:0]           held_bytes;
   logic [15:0]           skip_remaining;
   logic [CountBits-1:0]  records_seen;
   logic [3:0]            bytes_seen;

   iprc_pkg::rsp_word_type expected_words[$];
   logic [7:0]            file_data[$];
   int unsigned           send_idle_pct;
   int unsigned           rsp_stall_pct;
   int unsigned           items_sent;
   int unsigned           error_count;
   int unsigned           cycle_count;

   ips_patch_record_counter_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_size_ok   (rsp_size_ok),
      .rsp_magic_ok  (rsp_magic_ok),
      .rsp_rec_total (rsp_rec_total)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic clear_parse_state();
      walk_phase     = PARSE_MAGIC;
      field_index    = '0;
      magic_match    = 1'b1;
      held_bytes     = '0;
      skip_remaining = '0;
      records_seen   = '0;
      bytes_seen     = '0;
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // advance the mirror by one accepted byte; queue a result word on the final byte
   task automatic predict_parse(input logic [7:0] data, input logic last);
      iprc_pkg::rsp_word_type word;
      logic [15:0]  size_field;
      if (bytes_seen < iprc_pkg::MinFileBytes) bytes_seen++;
      case (walk_phase)
         PARSE_MAGIC: begin
            if (data != iprc_pkg::sig_byte(field_index)) magic_match = 1'b0;
            field_index++;
            if (field_index >= iprc_pkg::SigLength) begin
               field_index = '0;
               walk_phase  = magic_match ? PARSE_OFFSET : PARSE_DONE;
            end
         end
         PARSE_OFFSET: begin
            if (field_index < 2) begin
               held_bytes = {held_bytes[7:0], data};
               field_index++;
            end else begin
               field_index = '0;
               if (held_bytes == iprc_pkg::EofHigh && data == iprc_pkg::EofLow) begin
                  walk_phase = PARSE_DONE;
               end else begin
                  // record counts once its offset is complete
                  if (records_seen != '1) records_seen++;
                  held_bytes = '0;
                  walk_phase = PARSE_SIZE;
               end
            end
         end
         PARSE_SIZE: begin
            if (field_index == 0) begin
               held_bytes  = {8'h00, data};
               field_index = 3'd1;
            end else begin
               size_field     = {held_bytes[7:0], data};
               field_index    = '0;
               held_bytes     = '0;
               // zero size means an RLE record: two count bytes plus one value byte
               skip_remaining = (size_field == 16'd0) ? 16'd3 : size_field;
               walk_phase     = PARSE_SKIP;
            end
         end
         PARSE_SKIP: begin
            if (skip_remaining != 0) skip_remaining--;
            if (skip_remaining == 0) begin
               field_index = '0;
               held_bytes  = '0;
               walk_phase  = PARSE_OFFSET;
            end
         end
         default: ;
      endcase
      if (last) begin
         word.size_ok   = (bytes_seen >= iprc_pkg::MinFileBytes);
         word.magic_ok  = word.size_ok && magic_match;
         word.rec_total = '0;
         if (word.magic_ok) begin
            if (64'(records_seen) > 64'({iprc_pkg::RecordBits{1'b1}}))
               word.rec_total = '1;
            else
               word.rec_total = iprc_pkg::RecordBits'(records_seen);
         end
         expected_words.push_back(word);
         clear_parse_state();
      end
   endtask

   always @(posedge clock) begin
      iprc_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = expected_words.pop_front();
            if (rsp_size_ok !== want.size_ok)
               report_mismatch($sformatf("size_ok got %b want %b", rsp_size_ok, want.size_ok));
            if (rsp_magic_ok !== want.magic_ok)
               report_mismatch($sformatf("magic_ok got %b want %b",
                                         rsp_magic_ok, want.magic_ok));
            if (rsp_rec_total !== want.rec_total)
               report_mismatch($sformatf("rec_total got %0d want %0d",
                                         rsp_rec_total, want.rec_total));
         end
      end
   end

   // called just after a falling edge; returns just after a falling edge
   task automatic send_byte(input logic [7:0] data, input logic last);
      req_valid     = 1'b1;
      req_data_byte = data;
      req_last_byte = last;
      do @(posedge clock); while (!req_ready);
      predict_parse(data, last);
      items_sent++;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid     = 1'b0;
         req_data_byte = 8'($urandom);
         req_last_byte = 1'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic send_file();
      foreach (file_data[i]) send_byte(file_data[i], i == file_data.size() - 1);
   endtask

   task automatic load_signature();
      file_data.delete();
      for (int i = 0; i < iprc_pkg::SigLength; i++)
         file_data.push_back(iprc_pkg::sig_byte(3'(i)));
   endtask

   task automatic push_eof();
      file_data.push_back(iprc_pkg::EofHigh[15:8]);
      file_data.push_back(iprc_pkg::EofHigh[7:0]);
      file_data.push_back(iprc_pkg::EofLow);
   endtask

   task automatic build_random_file();
      int unsigned kind;
      int unsigned num_records;
      int unsigned size_value;
      int unsigned payload_len;
      int unsigned ending;
      int unsigned cut_len;
      int unsigned pos;
      kind = $urandom_range(99);
      if (kind < 10) begin
         // noise, often too short to parse
         file_data.delete();
         repeat ($urandom_range(1, 12)) file_data.push_back(8'($urandom));
      end else begin
         load_signature();
         if (kind < 18) begin
            pos = $urandom_range(iprc_pkg::SigLength - 1);
            file_data[pos] = file_data[pos] ^ (8'h01 << $urandom_range(7));
         end
         num_records = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
         repeat (num_records) begin
            repeat (3) file_data.push_back(8'($urandom));
            pos = $urandom_range(99);
            if (pos < 25)      size_value = 0;
            else if (pos < 85) size_value = $urandom_range(1, 6);
            else if (pos < 97) size_value = $urandom_range(7, 40);
            else               size_value = $urandom_range(41, 600);
            file_data.push_back(8'(size_value >> 8));
            file_data.push_back(8'(size_value));
            payload_len = (size_value == 0) ? 3 : size_value;
            repeat (payload_len) file_data.push_back(8'($urandom));
         end
         ending = $urandom_range(99);
         if (ending < 60) begin
            push_eof();
            repeat ($urandom_range(3)) file_data.push_back(8'($urandom));
         end else if (ending < 85) begin
            // chop the file anywhere, mid-record included
            cut_len = $urandom_range(1, file_data.size());
            while (file_data.size() > cut_len) void'(file_data.pop_back());
         end
      end
   endtask

   task automatic test_short_file();
      load_signature();
      file_data.push_back(8'hFF);
      file_data.push_back(8'h00);
      send_file();
   endtask

   task automatic test_eof_only();
      load_signature();
      push_eof();
      send_file();
   endtask

   task automatic test_truncated_record();
      load_signature();
      repeat (3) file_data.push_back(8'h00);
      send_file();
   endtask

   task automatic test_bad_signature();
      load_signature();
      file_data[iprc_pkg::SigLength-1] = iprc_pkg::SigByte4 ^ 8'h01;
      push_eof();
      send_file();
   endtask

   task automatic test_random_files(input int unsigned item_goal);
      int unsigned goal;
      goal = items_sent + item_goal;
      while (items_sent < goal) begin
         build_random_file();
         send_file();
      end
   endtask

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      items_sent    = 0;
      send_idle_pct = 16;
      rsp_stall_pct = 64;
      clear_parse_state();
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_file();
      test_eof_only();
      test_truncated_record();
      test_bad_signature();
      test_random_files(470);

      send_idle_pct = 64;
      rsp_stall_pct = 16;
      test_random_files(470);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_files(480);

      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/iprc_pkg.sv
hw/rtl/iprc_parser.sv
hw/rtl/iprc_rsp_queue.sv
hw/rtl/ips_patch_record_counter_unit.sv
dv/ips_patch_record_counter_unit_tb.sv
